// ----- rtl/dus_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the segment decode for the score display.
// No dependencies.
package dus_pkg;

  localparam logic [7:0] THRESHOLD_RESET = 8'd10;

  typedef struct packed {
    logic home_pressed;
    logic away_pressed;
    logic count_up;
  } in_item_t;

  typedef struct packed {
    logic       home_indicator;
    logic       reset_sent;
    logic       frame_sent;
    logic [6:0] seg_away_ones;
    logic [6:0] seg_away_tens;
    logic [6:0] seg_home_ones;
    logic [6:0] seg_home_tens;
  } out_item_t;

  // debouncer -> top
  typedef struct packed {
    logic press_accept;
    logic latched_next;
  } deb_status_t;

  // score unit -> top
  typedef struct packed {
    logic [7:0] score_next;
    logic       changed;
  } score_status_t;

  localparam logic [6:0] SEG_0 = 7'h7E;
  localparam logic [6:0] SEG_1 = 7'h30;
  localparam logic [6:0] SEG_2 = 7'h6D;
  localparam logic [6:0] SEG_3 = 7'h79;
  localparam logic [6:0] SEG_4 = 7'h33;
  localparam logic [6:0] SEG_5 = 7'h5B;
  localparam logic [6:0] SEG_6 = 7'h5F;
  localparam logic [6:0] SEG_7 = 7'h70;
  localparam logic [6:0] SEG_8 = 7'h7F;
  localparam logic [6:0] SEG_9 = 7'h7B;

  function automatic logic [6:0] seg_code(input logic [3:0] digit);
    logic [6:0] code;
    unique case (digit)
      4'd0:    code = SEG_0;
      4'd1:    code = SEG_1;
      4'd2:    code = SEG_2;
      4'd3:    code = SEG_3;
      4'd4:    code = SEG_4;
      4'd5:    code = SEG_5;
      4'd6:    code = SEG_6;
      4'd7:    code = SEG_7;
      4'd8:    code = SEG_8;
      4'd9:    code = SEG_9;
      default: code = SEG_0;
    endcase
    return code;
  endfunction

  // {tens segments, ones segments}; hundreds digit dropped.
  // x*205 >> 11 equals x/10 for every 8-bit x.
  function automatic logic [13:0] seg_pair(input logic [7:0] s);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  rem;
    logic [4:0]  tens;
    prod = 16'({8'd0, s} * 16'd205);
    q    = prod[15:11];
    rem  = s - ({3'd0, q} << 3) - ({3'd0, q} << 1);
    if (q >= 5'd20) begin
      tens = q - 5'd20;
    end else if (q >= 5'd10) begin
      tens = q - 5'd10;
    end else begin
      tens = q;
    end
    return {seg_code(tens[3:0]), seg_code(rem[3:0])};
  endfunction

endpackage

// ----- rtl/dus_debounce.sv -----
`timescale 1ns / 1ps
// Press/release debouncer for one button: shared tick count and latch.
// Depends on dus_pkg.
module dus_debounce import dus_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  threshold,
  input  logic        step,
  input  logic        pressed,
  output deb_status_t status
);

  logic [7:0] count;
  logic [7:0] count_next;
  logic [7:0] count_inc;
  logic       latched;
  logic       latched_next;
  logic       awaiting;
  logic       hit;

  always_comb begin
    awaiting     = pressed != latched;
    count_inc    = count + 8'd1;
    hit          = awaiting && (count_inc == threshold);
    count_next   = awaiting ? (hit ? 8'd0 : count_inc) : count;
    latched_next = hit ? pressed : latched;
  end

  assign status.press_accept = hit && pressed;
  assign status.latched_next = latched_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= 8'd0;
      latched <= 1'b0;
    end else if (step) begin
      count   <= count_next;
      latched <= latched_next;
    end
  end

endmodule

// ----- rtl/dus_score.sv -----
`timescale 1ns / 1ps
// One 8-bit wrapping score with clear and up/down step.
// Depends on dus_pkg.
module dus_score import dus_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          clear,
  input  logic          press,
  input  logic          up,
  output score_status_t status
);

  logic [7:0] score;
  logic [7:0] base;
  logic [7:0] score_next;

  // the shown copy always equals the score between beats, so a change
  // is measured against the score after the optional clear
  always_comb begin
    base       = clear ? 8'd0 : score;
    score_next = press ? (up ? base + 8'd1 : base - 8'd1) : base;
  end

  assign status.score_next = score_next;
  assign status.changed    = score_next != base;

  always_ff @(posedge clk) begin
    if (rst) begin
      score <= 8'd0;
    end else if (step) begin
      score <= score_next;
    end
  end

endmodule

// ----- rtl/debounced_updown_score_display.sv -----
`timescale 1ns / 1ps
// Top level: input register, debouncers, scores, segment decode, result register.
// Depends on dus_pkg, dus_debounce, dus_score.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------
//  in       | in_valid / in_stall          | in_data (in_item_t)
//  out      | out_valid / out_stall        | out_data (out_item_t)
//  config   | debounce_threshold_we        | debounce_threshold_wdata
//
// One beat per cycle sustained while out_stall is low.
// The state update and segment decode sit between the input and result regs.
// rst is synchronous; threshold returns to 10, all counts and scores to zero.
// in_stall rises only when the input register is full and the result
// register is held by out_stall.
module debounced_updown_score_display import dus_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       debounce_threshold_we,
  input  logic [7:0] debounce_threshold_wdata
);

  logic [7:0]    threshold;
  in_item_t      in_q;
  logic          in_q_valid;
  logic          advance;
  logic          clear;
  deb_status_t   home_deb;
  deb_status_t   away_deb;
  score_status_t home_st;
  score_status_t away_st;
  out_item_t     result;
  logic [13:0]   home_segs;
  logic [13:0]   away_segs;

  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;
  assign clear    = in_q.home_pressed && in_q.away_pressed;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (debounce_threshold_we) begin
      threshold <= debounce_threshold_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  dus_debounce u_home_deb (
    .clk       (clk),
    .rst       (rst),
    .threshold (threshold),
    .step      (advance),
    .pressed   (in_q.home_pressed),
    .status    (home_deb)
  );

  dus_debounce u_away_deb (
    .clk       (clk),
    .rst       (rst),
    .threshold (threshold),
    .step      (advance),
    .pressed   (in_q.away_pressed),
    .status    (away_deb)
  );

  dus_score u_home_score (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .clear  (clear),
    .press  (home_deb.press_accept),
    .up     (in_q.count_up),
    .status (home_st)
  );

  dus_score u_away_score (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .clear  (clear),
    .press  (away_deb.press_accept),
    .up     (in_q.count_up),
    .status (away_st)
  );

  always_comb begin
    home_segs              = seg_pair(home_st.score_next);
    away_segs              = seg_pair(away_st.score_next);
    result.home_indicator  = home_deb.latched_next;
    result.reset_sent      = clear;
    result.frame_sent      = home_st.changed || away_st.changed;
    result.seg_away_ones   = away_segs[6:0];
    result.seg_away_tens   = away_segs[13:7];
    result.seg_home_ones   = home_segs[6:0];
    result.seg_home_tens   = home_segs[13:7];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_data <= result;
    end
  end

  // back-pressure only when both registers are occupied and the sink stalls
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_q_valid && out_valid && out_stall))
    else $error("in_stall without a held result");

  // a clear beat with no accepted press shows all-zero digits
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.reset_sent && !out_data.frame_sent) |->
      (out_data.seg_away_ones == SEG_0 && out_data.seg_away_tens == SEG_0 &&
       out_data.seg_home_ones == SEG_0 && out_data.seg_home_tens == SEG_0))
    else $error("reset frame not zero");

  // nothing is presented in the cycle after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

endmodule
